### rtl/core/hls_lightness_saturation_adjust_macros.svh
// Assertion macros for the HLS lightness and saturation adjuster
`ifndef HLS_LIGHTNESS_SATURATION_ADJUST_MACROS_SVH
`define HLS_LIGHTNESS_SATURATION_ADJUST_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet during reset
`define HLSA_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hlsa: same-cycle check failed");
// Next-cycle implication, sampled on clk, quiet during reset
`define HLSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hlsa: next-cycle check failed");
`else
`define HLSA_ASSERT(lbl, ante, cons)
`define HLSA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/hlsa_pkg.sv
// Shared constants and types of the HLS lightness and saturation adjuster
package hlsa_pkg;

	// Q0.16 unit and Q9.8 hue angles
	localparam int UNIT_Q     = 65536;
	localparam int HALF_Q     = 32768;
	localparam int HUE_FULL_Q = 92160;
	localparam int HUE_60_Q   = 15360;
	localparam int HUE_120_Q  = 30720;
	localparam int HUE_180_Q  = 46080;
	localparam int HUE_240_Q  = 61440;

	// Widths
	localparam int Q_W   = 17;
	localparam int HQ_W  = 17;
	localparam int T_W   = 19;
	localparam int COF_W = 14;

	// Divider shape
	localparam int DIV_NW        = 25;
	localparam int DIV_DW        = 9;
	localparam int DIV_QW        = 17;
	localparam int DIV_STEPS_DEF = 2;

	// Reciprocals for division by constants
	localparam logic [15:0] DIV100_MUL = 16'd41944;
	localparam int          DIV100_SH  = 22;
	localparam logic [9:0]  DIV3_MUL   = 10'd683;
	localparam int          DIV3_SH    = 11;
	localparam logic [34:0] HQ_MUL     = 35'd24253937664;
	localparam int          HQ_SH      = 26;
	localparam logic [22:0] DIV15_MUL  = 23'd4473925;
	localparam int          DIV15_SH   = 26;

	// Ramp segment of a channel angle
	typedef enum logic [1:0] {
		RG_UP,
		RG_HI,
		RG_DN,
		RG_LO
	} region_t;

	// Grey override carried beside a channel
	typedef struct packed {
		logic       grey;
		logic [7:0] l8;
	} grey_t;

endpackage

### rtl/core/hlsa_div.sv
// Pipelined restoring divider, a few quotient bits per stage
module hlsa_div #(
	parameter int NW    = 25,
	parameter int DW    = 9,
	parameter int QW    = 17,
	parameter int SW    = 8,
	parameter int STEPS = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] out_side
);

	localparam int NST = (QW + STEPS - 1) / STEPS;
	localparam int TW  = DW + QW;
	localparam int CW  = (NW > TW) ? NW : TW;

	logic          vld_s  [0:NST];
	logic [NW-1:0] rem_s  [0:NST];
	logic [QW-1:0] quo_s  [0:NST];
	logic [DW-1:0] den_s  [0:NST];
	logic [SW-1:0] side_s [0:NST];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = num;
	assign quo_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [NW-1:0] rc [0:STEPS];
		logic [QW-1:0] qc [0:STEPS];

		assign rc[0] = rem_s[k];
		assign qc[0] = quo_s[k];

		// Resolve STEPS quotient bits, most significant first
		for (genvar j = 0; j < STEPS; j++) begin : g_step
			localparam int POS = QW - 1 - (k * STEPS + j);
			if (POS >= 0) begin : g_bit
				logic [CW-1:0] trial;
				logic          take;
				assign trial     = CW'(den_s[k]) << POS;
				assign take      = CW'(rc[j]) >= trial;
				assign rc[j + 1] = take ? NW'(CW'(rc[j]) - trial) : rc[j];
				assign qc[j + 1] = qc[j] | (QW'(take) << POS);
			end else begin : g_pass
				assign rc[j + 1] = rc[j];
				assign qc[j + 1] = qc[j];
			end
		end

		// Advance valid with the beat
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k + 1] <= 1'b0;
			end else if (en) begin
				vld_s[k + 1] <= vld_s[k];
			end
		end

		// Advance payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k + 1]  <= rc[STEPS];
				quo_s[k + 1]  <= qc[STEPS];
				den_s[k + 1]  <= den_s[k];
				side_s[k + 1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[NST];
	assign quo       = quo_s[NST];
	assign out_side  = side_s[NST];

endmodule

### rtl/core/hlsa_ramp.sv
// One output channel of the HLS-to-RGB ramp, four register stages
module hlsa_ramp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [hlsa_pkg::Q_W-1:0]     rm1,
	input  logic [hlsa_pkg::Q_W-1:0]     rm2,
	input  logic [hlsa_pkg::HQ_W-1:0]    t,
	input  hlsa_pkg::grey_t              side,
	output logic                         out_valid,
	output logic [7:0]                   chan
);

	import hlsa_pkg::*;

	logic                  v_s1, v_s2, v_s3, v_s4;
	region_t               rg_s1, rg_s2;
	logic [COF_W-1:0]      cof_s1;
	logic [Q_W-1:0]        dif_s1;
	logic [Q_W-1:0]        rm1_s1, rm1_s2;
	logic [Q_W-1:0]        rm2_s1, rm2_s2;
	logic [30:0]           prod_s2;
	logic [Q_W-1:0]        v_val_s3;
	grey_t                 side_s1, side_s2, side_s3;
	logic [7:0]            chan_s4;

	region_t               rg;
	logic [COF_W-1:0]      cof;
	logic [19:0]           z;
	logic [Q_W-1:0]        q;
	logic [Q_W-1:0]        v_val;
	logic [7:0]            byte_v;

	// Pick the segment and its distance from the ramp end
	always_comb begin
		priority if (t < HQ_W'(HUE_60_Q)) begin
			rg  = RG_UP;
			cof = COF_W'(t);
		end else if (t < HQ_W'(HUE_180_Q)) begin
			rg  = RG_HI;
			cof = '0;
		end else if (t < HQ_W'(HUE_240_Q)) begin
			rg  = RG_DN;
			cof = COF_W'(HQ_W'(HUE_240_Q) - t);
		end else begin
			rg  = RG_LO;
			cof = '0;
		end
	end

	// Divide the slope product by 15360: shift out 1024, then times 1/15
	assign z = 20'(prod_s2 >> 10);
	assign q = Q_W'((43'(z) * 43'(DIV15_MUL)) >> DIV15_SH);

	always_comb begin
		unique case (rg_s2)
			RG_UP, RG_DN: v_val = rm1_s2 + q;
			RG_HI:        v_val = rm2_s2;
			RG_LO:        v_val = rm1_s2;
			default:      v_val = rm1_s2;
		endcase
	end

	// Scale back to a byte
	assign byte_v = 8'((25'(v_val_s3) * 25'd255) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rg_s1    <= rg;
			cof_s1   <= cof;
			dif_s1   <= rm2 - rm1;
			rm1_s1   <= rm1;
			rm2_s1   <= rm2;
			side_s1  <= side;
			rg_s2    <= rg_s1;
			prod_s2  <= 31'(dif_s1) * 31'(cof_s1);
			rm1_s2   <= rm1_s1;
			rm2_s2   <= rm2_s1;
			side_s2  <= side_s1;
			v_val_s3 <= v_val;
			side_s3  <= side_s2;
			chan_s4  <= side_s3.grey ? side_s3.l8 : byte_v;
		end
	end

	assign out_valid = v_s4;
	assign chan      = chan_s4;

endmodule

### rtl/core/hls_lightness_saturation_adjust.sv
// Top level of the HLS lightness and saturation adjuster
//
//   channel | direction | handshake        | payload
//   in      | sink      | in_valid/ready   | in_color, lightness_percent, saturation_percent
//   out     | source    | out_valid/ready  | out_color
//
// One colour per clock while the output is not stalled; the hue and saturation dividers
// resolve DIV_STEPS quotient bits a stage.
// Reset clears the valid bits only; the block holds no colour state between beats.
// A stall on the output freezes every stage at once, so no beat is lost or repeated.
`include "hls_lightness_saturation_adjust_macros.svh"
module hls_lightness_saturation_adjust #(
	parameter int DIV_STEPS = hlsa_pkg::DIV_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        in_color,
	input  logic signed [7:0]  lightness_percent,
	input  logic signed [7:0]  saturation_percent,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        out_color
);

	import hlsa_pkg::*;

	logic adv;

	// Scale term of the percentage move: direction flag and product before /100
	function automatic logic [15:0] adj_term(input logic [7:0] v, input logic signed [7:0] pct);
		logic signed [7:0] pc;
		logic              pos;
		logic [6:0]        k;
		logic [7:0]        m;
		pc  = (pct > 8'sd100) ? 8'sd100 : ((pct < -8'sd100) ? -8'sd100 : pct);
		pos = pc > 8'sd0;
		k   = pos ? pc[6:0] : 7'(pc + 8'sd100);
		m   = pos ? (8'd255 - v) : v;
		return {pos, 15'(15'(m) * 15'(k))};
	endfunction

	// Stage 1: extremes, lightness, divider operands
	logic [7:0]         r, g, b, mx, mn, d8;
	logic [8:0]         sum9, sden9;
	logic               is_b, is_g;
	logic signed [8:0]  dif9;
	logic signed [15:0] dif60;
	logic [16:0]        base17;
	logic signed [18:0] hnum;
	logic [15:0]        snum16;

	assign r = in_color[7:0];
	assign g = in_color[15:8];
	assign b = in_color[23:16];

	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end

	assign d8     = mx - mn;
	assign sum9   = 9'(mx) + 9'(mn);
	assign sden9  = (sum9 <= 9'd255) ? sum9 : (9'd510 - sum9);
	assign snum16 = {d8, 8'd0} - 16'(d8);
	assign is_b   = (b == mx);
	assign is_g   = !is_b && (g == mx);

	// Hue numerator; blue wins ties over green, green over red
	always_comb begin
		priority if (is_b) begin
			dif9   = $signed({1'b0, r}) - $signed({1'b0, g});
			base17 = 17'(d8) * 17'd240;
		end else if (is_g) begin
			dif9   = $signed({1'b0, b}) - $signed({1'b0, r});
			base17 = 17'(d8) * 17'd120;
		end else begin
			dif9   = $signed({1'b0, g}) - $signed({1'b0, b});
			base17 = 17'(d8) * 17'd360;
		end
	end

	assign dif60 = 16'(dif9) * 16'sd60;
	assign hnum  = (!is_b && !is_g && (dif9 > 9'sd0)) ? 19'(dif60)
	             : ($signed(19'(base17)) + 19'(dif60));

	logic               v_s1, dnz_s1;
	logic [7:0]         l8_s1, d8_s1;
	logic signed [7:0]  pl_s1, ps_s1;
	logic [16:0]        hnum_s1;
	logic [15:0]        snum_s1;
	logic [8:0]         sden_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dnz_s1  <= (d8 != 8'd0);
			l8_s1   <= sum9[8:1];
			d8_s1   <= d8;
			pl_s1   <= lightness_percent;
			ps_s1   <= saturation_percent;
			hnum_s1 <= hnum[16:0];
			snum_s1 <= snum16;
			sden_s1 <= sden9;
		end
	end

	// Dividers: hue angle and saturation run side by side
	logic                 hv, sv;
	logic [DIV_QW-1:0]    hq_d, sq_d;
	logic [16:0]          hside;
	logic [7:0]           sside;

	hlsa_div #(
		.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW), .SW(17), .STEPS(DIV_STEPS)
	) u_div_hue (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.num({hnum_s1, 8'd0}), .den({1'b0, d8_s1}),
		.side({dnz_s1, l8_s1, pl_s1}),
		.out_valid(hv), .quo(hq_d), .out_side(hside)
	);

	hlsa_div #(
		.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW), .SW(8), .STEPS(DIV_STEPS)
	) u_div_sat (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s1),
		.num({9'd0, snum_s1}), .den(sden_s1),
		.side(ps_s1),
		.out_valid(sv), .quo(sq_d), .out_side(sside)
	);

	// Stage 2: hue to byte (first half), percentage products
	logic               dv, dnz_d;
	logic [7:0]         l8_d, s8_d;
	logic [HQ_W-1:0]    hq_eff;
	logic [15:0]        tl, ts;

	assign dv     = hv & sv;
	assign dnz_d  = hside[16];
	assign l8_d   = hside[15:8];
	assign hq_eff = dnz_d ? hq_d : '0;
	assign s8_d   = dnz_d ? sq_d[7:0] : 8'd0;
	assign tl     = adj_term(l8_d, $signed(hside[7:0]));
	assign ts     = adj_term(s8_d, $signed(sside));

	logic        v_s2, posl_s2, poss_s2;
	logic [9:0]  y_s2;
	logic [14:0] pl_prod_s2, ps_prod_s2;
	logic [7:0]  l8_s2, s8_s2;

	// Stage 3: hue byte, adjusted lightness and saturation
	logic [7:0]  ql, qs, l8a, s8a, h8;

	assign h8  = 8'((20'(y_s2) * 20'(DIV3_MUL)) >> DIV3_SH);
	assign ql  = 8'((31'(pl_prod_s2) * 31'(DIV100_MUL)) >> DIV100_SH);
	assign qs  = 8'((31'(ps_prod_s2) * 31'(DIV100_MUL)) >> DIV100_SH);
	assign l8a = posl_s2 ? (l8_s2 + ql) : ql;
	assign s8a = poss_s2 ? (s8_s2 + qs) : qs;

	logic        v_s3;
	logic [7:0]  h8_s3, l8a_s3, s8a_s3;

	// Stage 4: hue back to Q9.8, bytes to Q0.16
	logic [HQ_W-1:0] hq2;
	logic [Q_W-1:0]  lq, sq;

	assign hq2 = HQ_W'((43'(h8_s3) * 43'(HQ_MUL)) >> HQ_SH);
	assign lq  = (Q_W'(l8a_s3) * Q_W'(257)) + Q_W'(l8a_s3 != 8'd0);
	assign sq  = (Q_W'(s8a_s3) * Q_W'(257)) + Q_W'(s8a_s3 != 8'd0);

	logic            v_s4;
	logic [HQ_W-1:0] hq2_s4, hq2_s5;
	logic [Q_W-1:0]  l_s4, s_s4, l_s5, s_s5, p_s5;
	grey_t           gr_s4, gr_s5;

	// Stage 6: ramp ends and channel angles
	logic               v_s5;
	logic [18:0]        rm2_raw;
	logic [Q_W-1:0]     rm2;
	logic signed [18:0] rm1_raw;
	logic [Q_W-1:0]     rm1;
	logic signed [T_W-1:0] tr_raw, tb_raw;
	logic [HQ_W-1:0]    tr, tb;

	assign rm2_raw = (l_s5 <= Q_W'(HALF_Q)) ? (19'(l_s5) + 19'(p_s5))
	               : (19'(l_s5) + 19'(s_s5) - 19'(p_s5));
	assign rm2     = (rm2_raw > 19'(UNIT_Q)) ? Q_W'(UNIT_Q) : rm2_raw[Q_W-1:0];
	assign rm1_raw = $signed({1'b0, l_s5, 1'b0}) - $signed(19'(rm2));
	assign rm1     = (rm1_raw < 19'sd0) ? '0
	               : ((rm1_raw > 19'(UNIT_Q)) ? Q_W'(UNIT_Q) : rm1_raw[Q_W-1:0]);

	// Wrap channel angles back into one turn
	assign tr_raw = $signed(T_W'(hq2_s5)) + T_W'(HUE_120_Q);
	assign tb_raw = $signed(T_W'(hq2_s5)) - T_W'(HUE_120_Q);
	assign tr     = (tr_raw > T_W'(HUE_FULL_Q)) ? HQ_W'(tr_raw - T_W'(HUE_FULL_Q))
	              : HQ_W'(tr_raw);
	assign tb     = (tb_raw < T_W'(0)) ? HQ_W'(tb_raw + T_W'(HUE_FULL_Q)) : HQ_W'(tb_raw);

	logic            v_s6;
	logic [Q_W-1:0]  rm1_s6, rm2_s6;
	logic [HQ_W-1:0] tr_s6, tg_s6, tb_s6;
	grey_t           gr_s6;

	// Hold every stage while the output beat waits
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s2 <= dv;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2       <= 10'((21'(hq_eff) * 21'd17) >> 11);
			posl_s2    <= tl[15];
			poss_s2    <= ts[15];
			pl_prod_s2 <= tl[14:0];
			ps_prod_s2 <= ts[14:0];
			l8_s2      <= l8_d;
			s8_s2      <= s8_d;
			h8_s3      <= h8;
			l8a_s3     <= l8a;
			s8a_s3     <= s8a;
			hq2_s4     <= hq2;
			l_s4       <= lq;
			s_s4       <= sq;
			gr_s4      <= '{grey: (s8a_s3 == 8'd0), l8: l8a_s3};
			hq2_s5     <= hq2_s4;
			l_s5       <= l_s4;
			s_s5       <= s_s4;
			p_s5       <= Q_W'((34'(l_s4) * 34'(s_s4)) >> 16);
			gr_s5      <= gr_s4;
			rm1_s6     <= rm1;
			rm2_s6     <= rm2;
			tr_s6      <= tr;
			tg_s6      <= hq2_s5;
			tb_s6      <= tb;
			gr_s6      <= gr_s5;
		end
	end

	// Channel ramps, output register inside
	logic       vr, vg, vb;
	logic [7:0] cr, cg, cb;

	hlsa_ramp u_ramp_r (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.rm1(rm1_s6), .rm2(rm2_s6), .t(tr_s6), .side(gr_s6),
		.out_valid(vr), .chan(cr)
	);

	hlsa_ramp u_ramp_g (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.rm1(rm1_s6), .rm2(rm2_s6), .t(tg_s6), .side(gr_s6),
		.out_valid(vg), .chan(cg)
	);

	hlsa_ramp u_ramp_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.rm1(rm1_s6), .rm2(rm2_s6), .t(tb_s6), .side(gr_s6),
		.out_valid(vb), .chan(cb)
	);

	assign out_valid = vr & vg & vb;
	assign out_color = {cb, cg, cr};

	// Checks
	`HLSA_ASSERT(a_div_lanes_agree, 1'b1, hv == sv)
	`HLSA_ASSERT(a_hue_in_turn, dv && dnz_d, hq_d <= DIV_QW'(HUE_FULL_Q))
	`HLSA_ASSERT(a_ramp_ordered, v_s6, rm1_s6 <= rm2_s6)
	`HLSA_ASSERT_NEXT(a_stall_keeps_beat, v_s5 && !adv, v_s5)

endmodule
